### design/lfe_pkg.sv
`timescale 1ns / 1ps

package lfe_pkg;

    // buffer sizes
    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;

    // derived widths, count width and header length
    localparam int RX_AW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TX_AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int CNT_W  = 5;
    localparam int HEADER_BYTES = 2;

    typedef logic [7:0] t_byte;

    // input transaction kinds
    typedef enum logic [2:0] {
        KIND_BREAK    = 3'd0,
        KIND_BUS_BYTE = 3'd1,
        KIND_LOAD_TX  = 3'd2,
        KIND_START_TX = 3'd3,
        KIND_ARM_RX   = 3'd4,
        KIND_READ_RX  = 3'd5,
        KIND_ABORT    = 3'd6
    } t_kind;

    // reported events
    typedef enum logic [2:0] {
        EV_NONE           = 3'd0,
        EV_HEADER         = 3'd1,
        EV_DATA_COMPLETE  = 3'd2,
        EV_TX_DONE        = 3'd3,
        EV_BUS_CONFLICT   = 3'd4,
        EV_BREAK_IN_FRAME = 3'd5
    } t_event;

    // frame engine mode
    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } t_mode;

    // one result transaction
    typedef struct packed {
        logic             tx_valid;
        t_byte            tx_byte;
        t_event           event_res;
        t_mode            mode_now;
        logic [CNT_W-1:0] received_count;
        t_byte            read_byte;
    } t_result;

endpackage

### design/lfe_in_if.sv
`timescale 1ns / 1ps

interface lfe_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               kind;
    lfe_pkg::t_byte           byte_value;
    logic [3:0]               index;
    logic [lfe_pkg::CNT_W-1:0] count_value;

    modport source (
        output valid, kind, byte_value, index, count_value,
        input  ready
    );

    modport sink (
        input  valid, kind, byte_value, index, count_value,
        output ready
    );
endinterface

### design/lfe_out_if.sv
`timescale 1ns / 1ps

interface lfe_out_if;
    logic                      valid;
    logic                      ready;
    logic                      tx_valid;
    lfe_pkg::t_byte            tx_byte;
    logic [2:0]                event_res;
    logic [1:0]                mode_now;
    logic [lfe_pkg::CNT_W-1:0] received_count;
    lfe_pkg::t_byte            read_byte;

    modport source (
        output valid, tx_valid, tx_byte, event_res, mode_now, received_count, read_byte,
        input  ready
    );

    modport sink (
        input  valid, tx_valid, tx_byte, event_res, mode_now, received_count, read_byte,
        output ready
    );
endinterface

### design/lin_slave_frame_engine.sv
`timescale 1ns / 1ps

// LIN slave frame engine: every input transaction (break, bus byte, tx load, tx start,
// receive arm, rx read, abort) yields exactly one registered result transaction, and a
// new one can be accepted every cycle while the skid entry is free. The whole update is
// one pass of logic from the accepted input to a result register, followed by a second
// output entry, so input keeps flowing for one more transaction while the result side
// stalls. Both 16-entry byte buffers are flip-flops with a single read address each; the
// transmit side keeps the byte currently on the bus in a register for the echo compare.
// Reading an rx or tx entry that was never written returns an undefined byte.
module lin_slave_frame_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfe_in_if.sink      i_in,
    lfe_out_if.source   o_out
);

    // state
    lfe_pkg::t_mode                r_mode;
    lfe_pkg::t_mode                n_mode;
    lfe_pkg::t_byte                r_rx_store [lfe_pkg::RX_DEPTH];
    lfe_pkg::t_byte                r_tx_store [lfe_pkg::TX_DEPTH];
    logic [lfe_pkg::CNT_W-1:0]     r_rx_count, n_rx_count;
    logic                          r_rx_open, n_rx_open;
    logic [lfe_pkg::CNT_W-1:0]     r_expected, n_expected;
    logic                          r_armed, n_armed;
    logic [lfe_pkg::TX_AW-1:0]     r_tx_pos, n_tx_pos;
    logic [lfe_pkg::TX_AW-1:0]     r_tx_end, n_tx_end;
    lfe_pkg::t_byte                r_tx_cur, n_tx_cur;

    // output buffer
    lfe_pkg::t_result              r_head, r_skid;
    logic                          r_head_valid, r_skid_valid;
    lfe_pkg::t_result              n_res;

    // store read and write controls
    logic                          rx_we;
    logic                          tx_we;
    logic [lfe_pkg::TX_AW-1:0]     tx_rd_addr;
    lfe_pkg::t_byte                tx_rd_data;
    logic [lfe_pkg::CNT_W-1:0]     rx_count_inc;

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_head_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    // tx buffer read port: first byte on start, next byte otherwise
    assign tx_rd_addr = (lfe_pkg::t_kind'(i_in.kind) == lfe_pkg::KIND_START_TX)
                        ? '0 : r_tx_pos + 1'b1;
    assign tx_rd_data = r_tx_store[tx_rd_addr];
    assign rx_count_inc = r_rx_count + 1'b1;

    // next state and result for the accepted transaction
    always_comb begin
        n_mode     = r_mode;
        n_rx_count = r_rx_count;
        n_rx_open  = r_rx_open;
        n_expected = r_expected;
        n_armed    = r_armed;
        n_tx_pos   = r_tx_pos;
        n_tx_end   = r_tx_end;
        n_tx_cur   = r_tx_cur;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        n_res      = '0;
        n_res.event_res = lfe_pkg::EV_NONE;

        case (lfe_pkg::t_kind'(i_in.kind))
            lfe_pkg::KIND_BREAK: begin
                if (r_mode inside {lfe_pkg::MODE_RX, lfe_pkg::MODE_TX}) begin
                    n_res.event_res = lfe_pkg::EV_BREAK_IN_FRAME;
                end
                n_mode     = lfe_pkg::MODE_RX;
                n_rx_count = '0;
                n_rx_open  = 1'b1;
            end
            lfe_pkg::KIND_BUS_BYTE: begin
                if (r_mode == lfe_pkg::MODE_TX) begin
                    // echo check against the byte on the bus
                    if (r_tx_cur == i_in.byte_value) begin
                        if (r_tx_pos < r_tx_end) begin
                            n_tx_pos       = r_tx_pos + 1'b1;
                            n_tx_cur       = tx_rd_data;
                            n_res.tx_valid = 1'b1;
                            n_res.tx_byte  = tx_rd_data;
                        end else begin
                            n_mode          = lfe_pkg::MODE_WAIT;
                            n_res.event_res = lfe_pkg::EV_TX_DONE;
                        end
                    end else begin
                        n_mode          = lfe_pkg::MODE_WAIT;
                        n_res.event_res = lfe_pkg::EV_BUS_CONFLICT;
                    end
                end else if (r_rx_open && (int'(r_rx_count) < lfe_pkg::RX_DEPTH)) begin
                    // store received byte, drop once full
                    rx_we      = 1'b1;
                    n_rx_count = rx_count_inc;
                    if (int'(rx_count_inc) >= lfe_pkg::RX_DEPTH) begin
                        n_rx_open = 1'b0;
                    end
                    if (int'(rx_count_inc) == lfe_pkg::HEADER_BYTES) begin
                        n_res.event_res = lfe_pkg::EV_HEADER;
                    end else if (r_armed && (rx_count_inc == r_expected)) begin
                        n_armed         = 1'b0;
                        n_mode          = lfe_pkg::MODE_WAIT;
                        n_res.event_res = lfe_pkg::EV_DATA_COMPLETE;
                    end
                end
            end
            lfe_pkg::KIND_LOAD_TX: begin
                if (int'(i_in.index) < lfe_pkg::TX_DEPTH) begin
                    tx_we = 1'b1;
                    // keep the on-bus copy coherent
                    if (i_in.index[lfe_pkg::TX_AW-1:0] == r_tx_pos) begin
                        n_tx_cur = i_in.byte_value;
                    end
                end
            end
            lfe_pkg::KIND_START_TX: begin
                n_tx_pos = '0;
                n_tx_end = (int'(i_in.index) < lfe_pkg::TX_DEPTH)
                           ? i_in.index[lfe_pkg::TX_AW-1:0]
                           : lfe_pkg::TX_AW'(lfe_pkg::TX_DEPTH - 1);
                n_mode         = lfe_pkg::MODE_TX;
                n_tx_cur       = tx_rd_data;
                n_res.tx_valid = 1'b1;
                n_res.tx_byte  = tx_rd_data;
            end
            lfe_pkg::KIND_ARM_RX: begin
                if (i_in.count_value > r_rx_count) begin
                    n_expected = i_in.count_value;
                    n_armed    = 1'b1;
                end
            end
            lfe_pkg::KIND_READ_RX: begin
                if (int'(i_in.index) < lfe_pkg::RX_DEPTH) begin
                    n_res.read_byte = r_rx_store[i_in.index[lfe_pkg::RX_AW-1:0]];
                end
            end
            lfe_pkg::KIND_ABORT: begin
                n_mode  = lfe_pkg::MODE_WAIT;
                n_armed = 1'b0;
            end
            default: begin
            end
        endcase

        n_res.mode_now       = n_mode;
        n_res.received_count = n_rx_count;
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lfe_pkg::MODE_WAIT;
        end else if (in_fire) begin
            r_mode <= n_mode;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= '0;
            r_rx_open  <= 1'b1;
            r_expected <= '0;
            r_armed    <= 1'b0;
            r_tx_pos   <= '0;
            r_tx_end   <= '0;
        end else if (in_fire) begin
            r_rx_count <= n_rx_count;
            r_rx_open  <= n_rx_open;
            r_expected <= n_expected;
            r_armed    <= n_armed;
            r_tx_pos   <= n_tx_pos;
            r_tx_end   <= n_tx_end;
        end
    end

    // byte buffers and on-bus byte
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tx_cur <= n_tx_cur;
            if (rx_we) begin
                r_rx_store[r_rx_count[lfe_pkg::RX_AW-1:0]] <= i_in.byte_value;
            end
            if (tx_we) begin
                r_tx_store[i_in.index[lfe_pkg::TX_AW-1:0]] <= i_in.byte_value;
            end
        end
    end

    // two-entry result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (!in_fire) begin
                r_head_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_head_valid) begin
                r_head_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
            end else if (in_fire) begin
                r_head <= n_res;
            end
        end else if (in_fire) begin
            if (!r_head_valid) begin
                r_head <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out.valid          = r_head_valid;
    assign o_out.tx_valid       = r_head.tx_valid;
    assign o_out.tx_byte        = r_head.tx_byte;
    assign o_out.event_res      = r_head.event_res;
    assign o_out.mode_now       = r_head.mode_now;
    assign o_out.received_count = r_head.received_count;
    assign o_out.read_byte      = r_head.read_byte;

    // skid entry only fills behind a held head
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry valid without head entry");

    // buffer closes only when full
    a_closed_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rx_open |-> (int'(r_rx_count) == lfe_pkg::RX_DEPTH))
        else $error("rx buffer closed before full");

    // a break restarts reception
    a_break_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (lfe_pkg::t_kind'(i_in.kind) == lfe_pkg::KIND_BREAK))
        |=> (r_mode == lfe_pkg::MODE_RX) && (r_rx_count == '0) && r_rx_open)
        else $error("break did not restart reception");

    // transmit position never passes the last index
    a_tx_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == lfe_pkg::MODE_TX) |-> (r_tx_pos <= r_tx_end))
        else $error("tx position beyond last index");

endmodule
